// ----- rtl/bec_pkg.sv -----
package bec_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

// ----- rtl/bec_ram.sv -----
module bec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bipartite_edge_coloring.sv -----
// Channel  Direction  Handshake      Word
// in       input      valid / stall  op, left_vertex, right_vertex
// out      output     valid / stall  status, color
// cfg      input      valid / ready  color_count
//
// The neighbor table is one RAM with a read port and a write port. Each cycle it takes one
// read and one write. After reset a clearing pass writes every entry before the first word
// is taken. The table holds 2*MAX_SIDE times MAX_COLORS rounded up to a power of two
// entries, 2048 by default.
// Each word first scans the color slots of both ends. A read, a duplicate or a rejected
// insert is answered from the scans alone. An edge with a common free color then writes
// that color at both ends. Otherwise a path of alternating colors is flipped first, one
// path vertex at a time, for up to 2*MAX_SIDE vertices.
// One item is in work at a time. The next word can be taken in the cycle after a result is
// loaded. A stalled result holds only the final step of the next item.
module bipartite_edge_coloring #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_COLORS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [5:0] i_left_vertex,
    input  logic [5:0] i_right_vertex,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [4:0] o_color,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_color_count
);

    localparam int NVERT = 2 * MAX_SIDE;
    localparam int VW    = $clog2(NVERT);
    localparam int CW    = MAX_COLORS > 1 ? $clog2(MAX_COLORS) : 1;
    localparam int AW    = VW + CW;
    localparam int DEPTH = NVERT * (1 << CW);
    localparam int NW    = VW + 1;
    localparam int KW    = CW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SCAN_LAST, S_PICK, S_PRD_A, S_PRD_B,
        S_PWAIT, S_PWR_A, S_PWR_B, S_FIN_U, S_FIN_V
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_clr;
    logic [4:0]     r_cc;
    logic           r_op;
    logic [VW-1:0]  r_u, r_v, r_x;
    logic [KW-1:0]  r_c;
    logic           r_phase;     // 0 scan u, 1 scan v
    logic [KW-1:0]  r_found;
    logic [KW-1:0]  r_degu, r_degv;
    logic [MAX_COLORS-1:0] r_freeu, r_freev;
    logic [CW-1:0]  r_ca, r_cb;
    logic           r_cur_b;
    logic [NW-1:0]  r_sa, r_sb;
    logic [VW:0]    r_steps;
    logic           r_ovalid;
    logic [1:0]     r_status;
    logic [4:0]     r_color;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [NW-1:0]  wdata, rdata;
    logic [KW-1:0]  cc_eff;
    logic [CW-1:0]  cidx;

    // Vertex index modulo MAX_SIDE by conditional subtraction of shifted multiples.
    function automatic logic [5:0] wrap_side(input logic [5:0] x);
        logic [13:0] r;
        r = 14'(x);
        for (int k = 5; k >= 0; k--) begin
            if (r >= (14'(MAX_SIDE) << k)) r = r - (14'(MAX_SIDE) << k);
        end
        return 6'(r);
    endfunction

    bec_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign cc_eff = (8'(r_cc) > 8'(MAX_COLORS)) ? KW'(MAX_COLORS) : KW'(r_cc);
    assign cidx   = r_c[CW-1:0];

    logic in_acc;
    logic out_free;
    assign out_free    = !r_ovalid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_color  = r_color;

    // lowest common free color within active range, highest free at each end
    logic          has_common;
    logic [CW-1:0] common_c, hi_u, hi_v;
    always_comb begin
        has_common = 1'b0;
        common_c = '0;
        hi_u = '0;
        hi_v = '0;
        for (int k = MAX_COLORS - 1; k >= 0; k--) begin
            if (KW'(k) < cc_eff && r_freeu[k] && r_freev[k]) begin
                has_common = 1'b1;
                common_c = CW'(k);
            end
        end
        for (int k = 0; k < MAX_COLORS; k++) begin
            if (KW'(k) < cc_eff && r_freeu[k]) hi_u = CW'(k);
            if (KW'(k) < cc_eff && r_freev[k]) hi_v = CW'(k);
        end
    end

    // Result of a word that needs no table update.
    logic       pick_done;
    logic [1:0] pick_status;
    logic [4:0] pick_color;
    always_comb begin
        pick_done   = 1'b1;
        pick_status = bec_pkg::ST_OK;
        pick_color  = '0;
        priority if (r_op == bec_pkg::OP_READ) begin
            if (r_found == KW'(MAX_COLORS)) pick_status = bec_pkg::ST_DUP;
            else pick_color = 5'(r_found) + 5'd1;
        end else if (r_found != KW'(MAX_COLORS)) begin
            pick_status = bec_pkg::ST_DUP;
        end else if (r_degu >= cc_eff || r_degv >= cc_eff) begin
            pick_status = bec_pkg::ST_FULL;
        end else begin
            pick_done = 1'b0;
        end
    end

    logic load_res;
    logic n_ovalid;
    assign load_res = out_free && ((r_state == S_PICK && pick_done) || r_state == S_FIN_V);
    assign n_ovalid = load_res || (r_ovalid && i_stall);

    logic [VW-1:0] scan_vtx;
    logic [VW-1:0] nxt_vtx;
    assign scan_vtx = r_phase ? r_v : r_u;
    assign nxt_vtx  = VW'(r_cur_b ? r_sb - NW'(1) : r_sa - NW'(1));

    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = {scan_vtx, cidx};
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_clr;
            end
            S_PICK:  raddr = {r_x, r_ca};
            S_PRD_A: raddr = {r_x, r_cb};
            S_PRD_B: raddr = {r_x, r_ca};
            S_PWR_A: begin
                we = 1'b1; waddr = {r_x, r_ca}; wdata = r_sb;
            end
            S_PWR_B: begin
                we = 1'b1; waddr = {r_x, r_cb}; wdata = r_sa;
            end
            S_FIN_U: begin
                we = 1'b1; waddr = {r_u, r_cb}; wdata = NW'(r_v) + NW'(1);
            end
            S_FIN_V: begin
                we = 1'b1; waddr = {r_v, r_cb}; wdata = NW'(r_u) + NW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cc     <= 5'd16;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) r_cc <= i_cfg_color_count;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_op;
                        r_u     <= VW'(wrap_side(i_left_vertex));
                        r_v     <= VW'(wrap_side(i_right_vertex)) + VW'(MAX_SIDE);
                        r_c     <= '0;
                        r_phase <= 1'b0;
                        r_found <= KW'(MAX_COLORS);
                        r_degu  <= '0;
                        r_degv  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // address r_c issued now, data of r_c-1 arrives
                    if (r_c != 0) begin
                        if (!r_phase && rdata == NW'(r_v) + NW'(1) && r_found == KW'(MAX_COLORS))
                            r_found <= r_c - KW'(1);
                        if (r_phase) r_freev[CW'(r_c - KW'(1))] <= (rdata == '0);
                        else r_freeu[CW'(r_c - KW'(1))] <= (rdata == '0);
                        if (rdata != '0) begin
                            if (r_phase) r_degv <= r_degv + KW'(1);
                            else r_degu <= r_degu + KW'(1);
                        end
                    end
                    if (r_c == KW'(MAX_COLORS - 1)) r_state <= S_SCAN_LAST;
                    r_c <= r_c + KW'(1);
                end
                S_SCAN_LAST: begin
                    if (!r_phase && rdata == NW'(r_v) + NW'(1) && r_found == KW'(MAX_COLORS))
                        r_found <= KW'(MAX_COLORS - 1);
                    if (r_phase) r_freev[MAX_COLORS-1] <= (rdata == '0);
                    else r_freeu[MAX_COLORS-1] <= (rdata == '0);
                    if (rdata != '0) begin
                        if (r_phase) r_degv <= r_degv + KW'(1);
                        else r_degu <= r_degu + KW'(1);
                    end
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_c     <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (pick_done) begin
                        if (out_free) begin
                            r_status <= pick_status;
                            r_color  <= pick_color;
                            r_state  <= S_IDLE;
                        end
                    end else if (has_common) begin
                        r_cb    <= common_c;
                        r_state <= S_FIN_U;
                    end else begin
                        r_ca    <= hi_u;
                        r_cb    <= hi_v;
                        r_x     <= r_u;
                        r_cur_b <= 1'b1;
                        r_steps <= '0;
                        r_state <= S_PRD_A;
                    end
                end
                // Slot cb of x is read first, then slot ca.
                S_PRD_A: r_state <= S_PRD_B;
                S_PRD_B: begin
                    r_sb    <= rdata; // slot cb of x
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    r_state <= S_PWR_A;
                end
                S_PWR_A: r_state <= S_PWR_B;
                S_PWR_B: begin
                    r_steps <= r_steps + (VW+1)'(1);
                    if ((r_cur_b ? r_sb : r_sa) == '0 ||
                        r_steps == (VW+1)'(NVERT - 1)) begin
                        r_state <= S_FIN_U;
                    end else begin
                        r_x     <= nxt_vtx;
                        r_cur_b <= !r_cur_b;
                        r_state <= S_PRD_A;
                    end
                end
                S_FIN_U: r_state <= S_FIN_V;
                S_FIN_V: begin
                    // Repeating the write while the output is held is harmless.
                    if (out_free) begin
                        r_status <= bec_pkg::ST_OK;
                        r_color  <= 5'(r_cb) + 5'd1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Slot ca of x, read in S_PRD_B, arrives in S_PWAIT.
    logic r_ca_pend;
    always_ff @(posedge i_clk) begin
        if (r_state == S_PWAIT) r_sa <= rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ca_pend <= 1'b0;
        else r_ca_pend <= (r_state == S_PRD_B);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_color)))
        else $error("result changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bec_pkg::ST_OK) |-> (o_color == 5'd0))
        else $error("color on rejected word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE))
        else $error("config taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ca_pend |-> (r_state == S_PWAIT))
        else $error("path read sequence broken");

endmodule
